// ===== rtl/core/breakpoint_match_table_defines.svh =====
// assertion macros for the breakpoint match table
`ifndef BREAKPOINT_MATCH_TABLE_DEFINES_SVH
`define BREAKPOINT_MATCH_TABLE_DEFINES_SVH

// same-cycle implication, checked on every rising clock edge outside reset
`define BMT_ASSERT_NOW(label, clk, rst, cond, expr, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (expr)) \
      else $error(msg);

// next-cycle implication, checked on every rising clock edge outside reset
`define BMT_ASSERT_NEXT(label, clk, rst, cond, expr, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (expr)) \
      else $error(msg);

`endif

// ===== rtl/core/bmt_pkg.sv =====
// shared types and codes for the breakpoint match table
`default_nettype none

package bmt_pkg;

   localparam int OP_BITS   = 3;
   localparam int KIND_BITS = 2;

   // operation codes
   localparam logic [OP_BITS-1:0] OP_SET    = 3'd0;
   localparam logic [OP_BITS-1:0] OP_REMOVE = 3'd1;
   localparam logic [OP_BITS-1:0] OP_CLEAR  = 3'd2;
   localparam logic [OP_BITS-1:0] OP_CHECK  = 3'd3;
   localparam logic [OP_BITS-1:0] OP_ARM    = 3'd4;

   // slot kinds
   localparam logic [KIND_BITS-1:0] KIND_EMPTY = 2'd0;
   localparam logic [KIND_BITS-1:0] KIND_WRITE = 2'd1;
   localparam logic [KIND_BITS-1:0] KIND_FETCH = 2'd2;

   // commands to the slot array, already qualified by the pipeline advance
   typedef struct packed {
      logic                 set_en;
      logic                 remove_en;
      logic                 clear_en;
      logic                 check_en;
      logic [KIND_BITS-1:0] kind;
   } slot_ctrl_type;

   // answers from the slot array for the current request
   typedef struct packed {
      logic hit;
      logic full;
   } slot_status_type;

endpackage

`default_nettype wire

// ===== rtl/core/breakpoint_match_table.sv =====
// top level of the breakpoint match table
//
// usage
//   requests enter on req_valid/req_ready carrying req_operation (set, remove,
//   clear all, check, arm ignore-once), req_address and req_kind (write or
//   fetch); every request yields exactly one response on rsp_valid/rsp_ready
//   with rsp_hit (check only) and rsp_full_res (set only)
//   a request accepted at one edge is registered in the input register,
//   compared against all slots in parallel as it advances and its response
//   is registered in the response register; throughput is one request per
//   cycle while responses are taken: the slot array is read, compared and
//   updated in the same cycle, so back-to-back requests see each other
//   synchronous reset empties every slot, disarms the skip and drops any
//   request or response in flight; slot and skip addresses are not cleared
//   if the receiver stalls, the response register holds and the input
//   register keeps one request waiting behind it; req_ready falls only
//   when both are occupied
`default_nettype none

`include "breakpoint_match_table_defines.svh"

module breakpoint_match_table #(
   parameter int SLOTS     = 32,
   parameter int ADDR_BITS = 24
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_valid,
   output logic                                   req_ready,
   input  wire logic [bmt_pkg::OP_BITS-1:0]       req_operation,
   input  wire logic [ADDR_BITS-1:0]              req_address,
   input  wire logic [bmt_pkg::KIND_BITS-1:0]     req_kind,
   output logic                                   rsp_valid,
   input  wire logic                              rsp_ready,
   output logic                                   rsp_hit,
   output logic                                   rsp_full_res
);

   // input register
   logic                              in_valid_ff;
   logic [bmt_pkg::OP_BITS-1:0]       op_ff;
   logic [ADDR_BITS-1:0]              addr_ff;
   logic [bmt_pkg::KIND_BITS-1:0]     kind_ff;

   // one-shot skip
   logic                 skip_armed_ff;
   logic                 skip_armed_in;
   logic [ADDR_BITS-1:0] skip_address_ff;

   // response register
   logic rsp_valid_ff;
   logic rsp_hit_ff;
   logic rsp_full_ff;

   logic advance;
   logic kind_ok;
   logic skip_match;
   logic is_check;
   logic is_arm;

   bmt_pkg::slot_ctrl_type   slot_ctrl;
   bmt_pkg::slot_status_type slot_status;

   // the registered request moves on when the response slot is free or draining
   assign advance   = in_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ready) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         op_ff   <= req_operation;
         addr_ff <= req_address;
         kind_ff <= req_kind;
      end
   end

   // decode
   assign kind_ok    = kind_ff inside {bmt_pkg::KIND_WRITE, bmt_pkg::KIND_FETCH};
   assign skip_match = skip_armed_ff && (skip_address_ff == addr_ff);
   assign is_check   = (op_ff == bmt_pkg::OP_CHECK);
   assign is_arm     = (op_ff == bmt_pkg::OP_ARM);

   // a matching armed skip masks the check for every kind
   always_comb begin
      slot_ctrl.set_en    = advance && (op_ff == bmt_pkg::OP_SET) && kind_ok;
      slot_ctrl.remove_en = advance && (op_ff == bmt_pkg::OP_REMOVE);
      slot_ctrl.clear_en  = advance && (op_ff == bmt_pkg::OP_CLEAR);
      slot_ctrl.check_en  = advance && is_check && kind_ok && !skip_match;
      slot_ctrl.kind      = kind_ff;
   end

   bmt_slots #(
      .SLOTS     (SLOTS),
      .ADDR_BITS (ADDR_BITS)
   ) u_slots (
      .clock   (clock),
      .reset   (reset),
      .ctrl    (slot_ctrl),
      .address (addr_ff),
      .status  (slot_status)
   );

   // skip is consumed by a matching check, replaced by a new arm
   always_comb begin
      skip_armed_in = skip_armed_ff;
      if (advance && is_arm) begin
         skip_armed_in = 1'b1;
      end else if (advance && is_check && skip_match) begin
         skip_armed_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         skip_armed_ff <= 1'b0;
      end else begin
         skip_armed_ff <= skip_armed_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && is_arm) begin
         skip_address_ff <= addr_ff;
      end
   end

   // response register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_hit_ff  <= slot_status.hit;
         rsp_full_ff <= slot_status.full;
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_hit      = rsp_hit_ff;
   assign rsp_full_res = rsp_full_ff;

   // checks

   // a response can never flag both a hit and a full table
   `BMT_ASSERT_NOW(a_hit_full_exclusive, clock, reset, rsp_valid_ff,
      !(rsp_hit_ff && rsp_full_ff), "response flags both hit and full")

   // an accepted request always lands in the input register
   `BMT_ASSERT_NEXT(a_req_captured, clock, reset, req_valid && req_ready,
      in_valid_ff, "accepted request lost")

   // a check that matches the armed skip uses it up
   `BMT_ASSERT_NEXT(a_skip_consumed, clock, reset, advance && is_check && skip_match,
      !skip_armed_ff, "skip not consumed by matching check")

   // arming leaves the skip armed with the new address
   `BMT_ASSERT_NEXT(a_skip_armed, clock, reset, advance && is_arm,
      skip_armed_ff && (skip_address_ff == $past(addr_ff)), "skip not armed")

endmodule

`default_nettype wire

// ===== rtl/core/bmt_slots.sv =====
// breakpoint slot array with parallel address comparators
`default_nettype none

module bmt_slots #(
   parameter int SLOTS     = 32,
   parameter int ADDR_BITS = 24
) (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire bmt_pkg::slot_ctrl_type  ctrl,
   input  wire logic [ADDR_BITS-1:0]    address,
   output bmt_pkg::slot_status_type     status
);

   logic [bmt_pkg::KIND_BITS-1:0] kind_ff [SLOTS];
   logic [bmt_pkg::KIND_BITS-1:0] kind_in [SLOTS];
   logic [ADDR_BITS-1:0]          addr_ff [SLOTS];

   logic [SLOTS-1:0] empty;
   logic [SLOTS-1:0] addr_eq;
   logic [SLOTS-1:0] kind_hit;
   logic [SLOTS-1:0] first_empty;

   always_comb begin
      for (int i = 0; i < SLOTS; i++) begin
         empty[i]    = (kind_ff[i] == bmt_pkg::KIND_EMPTY);
         addr_eq[i]  = (addr_ff[i] == address);
         kind_hit[i] = (kind_ff[i] == ctrl.kind) && addr_eq[i];
      end
   end

   // isolate the lowest set bit of the empty mask
   assign first_empty = empty & (~empty + SLOTS'(1));

   assign status.hit  = ctrl.check_en & (|kind_hit);
   assign status.full = ctrl.set_en & ~(|empty);

   always_comb begin
      for (int i = 0; i < SLOTS; i++) begin
         kind_in[i] = kind_ff[i];
         if (ctrl.clear_en || (ctrl.remove_en && addr_eq[i])) begin
            kind_in[i] = bmt_pkg::KIND_EMPTY;
         end else if (ctrl.set_en && first_empty[i]) begin
            kind_in[i] = ctrl.kind;
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < SLOTS; i++) begin
         if (reset) begin
            kind_ff[i] <= bmt_pkg::KIND_EMPTY;
         end else begin
            kind_ff[i] <= kind_in[i];
         end
      end
   end

   // addresses carry no reset, only written by a set
   always_ff @(posedge clock) begin
      for (int i = 0; i < SLOTS; i++) begin
         if (ctrl.set_en && first_empty[i] && !ctrl.clear_en) begin
            addr_ff[i] <= address;
         end
      end
   end

endmodule

`default_nettype wire

// ===== tb/tb_breakpoint_match_table.sv =====
// self-checking testbench for the breakpoint match table
`default_nettype none

module tb_breakpoint_match_table;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int SLOTS     = 32;
   localparam int ADDR_BITS = 24;
   localparam int HOT_COUNT = 16;

   localparam logic [ADDR_BITS-1:0] ADDR_MIN = '0;
   localparam logic [ADDR_BITS-1:0] ADDR_MAX = '1;

   // codes the package leaves unnamed: kind 3 and the unused operations
   localparam logic [bmt_pkg::KIND_BITS-1:0] KIND_RSVD   = 2'd3;
   localparam logic [bmt_pkg::OP_BITS-1:0]   OP_RSVD_LO  = 3'd5;
   localparam logic [bmt_pkg::OP_BITS-1:0]   OP_RSVD_MID = 3'd6;
   localparam logic [bmt_pkg::OP_BITS-1:0]   OP_RSVD_HI  = 3'd7;

   // how a directed row gets its expected response
   localparam logic TYPED   = 1'b1;
   localparam logic PREDICT = 1'b0;

   typedef struct packed {
      logic hit;
      logic full;
   } answer_type;

   typedef struct packed {
      logic [bmt_pkg::OP_BITS-1:0]   op;
      logic [ADDR_BITS-1:0]          addr;
      logic [bmt_pkg::KIND_BITS-1:0] kind;
      logic                          typed;
      logic                          hit;
      logic                          full;
   } stim_row_type;

   typedef enum int {IDLE_NONE, IDLE_LIGHT, IDLE_HEAVY} idle_style_type;

   logic                          clock;
   logic                          reset;
   logic                          req_valid;
   logic                          req_ready;
   logic [bmt_pkg::OP_BITS-1:0]   req_operation;
   logic [ADDR_BITS-1:0]          req_address;
   logic [bmt_pkg::KIND_BITS-1:0] req_kind;
   logic                          rsp_valid;
   logic                          rsp_ready;
   logic                          rsp_hit;
   logic                          rsp_full_res;

   // side information riding along with the request, never seen by the block
   logic       req_typed;
   answer_type req_typed_answer;

   // shadow copy of the breakpoint slots and the one-shot skip
   logic [bmt_pkg::KIND_BITS-1:0] shadow_kind [SLOTS];
   logic [ADDR_BITS-1:0]          shadow_addr [SLOTS];
   logic                          shadow_skip_armed;
   logic [ADDR_BITS-1:0]          shadow_skip_addr;

   answer_type pending_answers [$];
   int         mismatch_count;

   idle_style_type req_style;
   idle_style_type rsp_style;
   int             req_count;
   int             rsp_count;

   logic [ADDR_BITS-1:0] hot_addr [HOT_COUNT];
   logic [ADDR_BITS-1:0] last_armed;

   // directed rows; expected values typed in only where they are obvious
   stim_row_type directed_rows [26] = '{
      // arm the skip on address zero, then consume it with a check
      {bmt_pkg::OP_ARM,    ADDR_MIN,   bmt_pkg::KIND_WRITE, TYPED,   1'b0, 1'b0},
      {bmt_pkg::OP_SET,    ADDR_MIN,   bmt_pkg::KIND_WRITE, TYPED,   1'b0, 1'b0},
      {bmt_pkg::OP_CHECK,  ADDR_MIN,   bmt_pkg::KIND_WRITE, TYPED,   1'b0, 1'b0},
      {bmt_pkg::OP_CHECK,  ADDR_MIN,   bmt_pkg::KIND_WRITE, TYPED,   1'b1, 1'b0},
      // same address, other kind
      {bmt_pkg::OP_CHECK,  ADDR_MIN,   bmt_pkg::KIND_FETCH, PREDICT, 1'b0, 1'b0},
      // all-ones address
      {bmt_pkg::OP_SET,    ADDR_MAX,   bmt_pkg::KIND_FETCH, TYPED,   1'b0, 1'b0},
      {bmt_pkg::OP_CHECK,  ADDR_MAX,   bmt_pkg::KIND_FETCH, TYPED,   1'b1, 1'b0},
      // set with a bad kind stores nothing
      {bmt_pkg::OP_SET,    24'h123456, bmt_pkg::KIND_EMPTY, TYPED,   1'b0, 1'b0},
      {bmt_pkg::OP_SET,    24'h123456, KIND_RSVD,           TYPED,   1'b0, 1'b0},
      {bmt_pkg::OP_CHECK,  24'h123456, bmt_pkg::KIND_WRITE, PREDICT, 1'b0, 1'b0},
      // duplicate set takes two slots, one remove drops both
      {bmt_pkg::OP_SET,    24'hABCDEF, bmt_pkg::KIND_WRITE, PREDICT, 1'b0, 1'b0},
      {bmt_pkg::OP_SET,    24'hABCDEF, bmt_pkg::KIND_WRITE, PREDICT, 1'b0, 1'b0},
      {bmt_pkg::OP_CHECK,  24'hABCDEF, bmt_pkg::KIND_WRITE, PREDICT, 1'b0, 1'b0},
      {bmt_pkg::OP_REMOVE, 24'hABCDEF, bmt_pkg::KIND_WRITE, TYPED,   1'b0, 1'b0},
      {bmt_pkg::OP_CHECK,  24'hABCDEF, bmt_pkg::KIND_WRITE, PREDICT, 1'b0, 1'b0},
      // re-arming replaces the skip address
      {bmt_pkg::OP_ARM,    24'h555555, bmt_pkg::KIND_FETCH, TYPED,   1'b0, 1'b0},
      {bmt_pkg::OP_ARM,    24'hAAAAAA, bmt_pkg::KIND_WRITE, TYPED,   1'b0, 1'b0},
      // check with a bad kind never hits but still uses up a matching skip
      {bmt_pkg::OP_CHECK,  24'h555555, KIND_RSVD,           PREDICT, 1'b0, 1'b0},
      {bmt_pkg::OP_CHECK,  24'hAAAAAA, KIND_RSVD,           TYPED,   1'b0, 1'b0},
      {bmt_pkg::OP_SET,    24'hAAAAAA, bmt_pkg::KIND_FETCH, PREDICT, 1'b0, 1'b0},
      {bmt_pkg::OP_CHECK,  24'hAAAAAA, bmt_pkg::KIND_FETCH, PREDICT, 1'b0, 1'b0},
      // unused operation codes do nothing
      {OP_RSVD_LO,         ADDR_MAX,   KIND_RSVD,           TYPED,   1'b0, 1'b0},
      {OP_RSVD_MID,        24'hAAAAAA, bmt_pkg::KIND_FETCH, TYPED,   1'b0, 1'b0},
      {OP_RSVD_HI,         ADDR_MIN,   bmt_pkg::KIND_EMPTY, TYPED,   1'b0, 1'b0},
      // clear all, after which nothing can hit
      {bmt_pkg::OP_CLEAR,  ADDR_MIN,   bmt_pkg::KIND_WRITE, TYPED,   1'b0, 1'b0},
      {bmt_pkg::OP_CHECK,  ADDR_MAX,   bmt_pkg::KIND_FETCH, TYPED,   1'b0, 1'b0}
   };

   breakpoint_match_table #(
      .SLOTS     (SLOTS),
      .ADDR_BITS (ADDR_BITS)
   ) dut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_operation (req_operation),
      .req_address   (req_address),
      .req_kind      (req_kind),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_hit       (rsp_hit),
      .rsp_full_res  (rsp_full_res)
   );

   // 10 ns clock
   initial clock = 1'b0;
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // applies one request to the shadow table and returns the response it owes
   function automatic answer_type table_answer(input logic [bmt_pkg::OP_BITS-1:0]   op,
                                               input logic [ADDR_BITS-1:0]          addr,
                                               input logic [bmt_pkg::KIND_BITS-1:0] kind);
      answer_type ans;
      logic       kind_ok;
      logic       placed;
      ans     = '0;
      kind_ok = (kind == bmt_pkg::KIND_WRITE) || (kind == bmt_pkg::KIND_FETCH);
      placed  = 1'b0;
      case (op)
         bmt_pkg::OP_SET: begin
            if (kind_ok) begin
               // lowest empty slot wins
               for (int i = 0; i < SLOTS; i++) begin
                  if (!placed && shadow_kind[i] == bmt_pkg::KIND_EMPTY) begin
                     shadow_kind[i] = kind;
                     shadow_addr[i] = addr;
                     placed         = 1'b1;
                  end
               end
               ans.full = !placed;
            end
         end
         bmt_pkg::OP_REMOVE: begin
            for (int i = 0; i < SLOTS; i++)
               if (shadow_addr[i] == addr) shadow_kind[i] = bmt_pkg::KIND_EMPTY;
         end
         bmt_pkg::OP_CLEAR: begin
            for (int i = 0; i < SLOTS; i++) shadow_kind[i] = bmt_pkg::KIND_EMPTY;
         end
         bmt_pkg::OP_CHECK: begin
            // an armed skip on this address swallows the check, any kind
            if (shadow_skip_armed && shadow_skip_addr == addr) begin
               shadow_skip_armed = 1'b0;
            end else if (kind_ok) begin
               for (int i = 0; i < SLOTS; i++)
                  if (shadow_kind[i] == kind && shadow_addr[i] == addr) ans.hit = 1'b1;
            end
         end
         bmt_pkg::OP_ARM: begin
            shadow_skip_armed = 1'b1;
            shadow_skip_addr  = addr;
         end
         default: begin
         end
      endcase
      return ans;
   endfunction

   // idle cycles ahead of the next request or response
   function automatic int pick_wait(input idle_style_type style);
      case (style)
         IDLE_NONE:  return 0;
         IDLE_LIGHT: return ($urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : 0;
         default:    return $urandom_range(0, 18);
      endcase
   endfunction

   // mostly a small set of hot addresses so checks and removes find them
   function automatic logic [ADDR_BITS-1:0] pick_address();
      if ($urandom_range(0, 99) < 85) return hot_addr[$urandom_range(0, HOT_COUNT - 1)];
      return ADDR_BITS'($urandom());
   endfunction

   function automatic logic [bmt_pkg::KIND_BITS-1:0] pick_kind();
      if ($urandom_range(0, 24) == 0)
         return $urandom_range(0, 1) ? KIND_RSVD : bmt_pkg::KIND_EMPTY;
      return $urandom_range(0, 1) ? bmt_pkg::KIND_FETCH : bmt_pkg::KIND_WRITE;
   endfunction

   // drives one request from a falling edge and returns once it is taken
   task automatic send_request(input logic [bmt_pkg::OP_BITS-1:0]   op,
                               input logic [ADDR_BITS-1:0]          addr,
                               input logic [bmt_pkg::KIND_BITS-1:0] kind,
                               input logic                          typed,
                               input answer_type                    typed_ans);
      int gap;
      if (req_count % 50 == 0) req_style = idle_style_type'($urandom_range(0, 2));
      req_count++;
      gap = pick_wait(req_style);
      @(negedge clock);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid        <= 1'b1;
      req_operation    <= op;
      req_address      <= addr;
      req_kind         <= kind;
      req_typed        <= typed;
      req_typed_answer <= typed_ans;
      do @(posedge clock); while (!req_ready);
   endtask

   // response side: stalls drawn per response, released only at falling edges
   initial begin
      int gap;
      rsp_ready = 1'b0;
      rsp_count = 0;
      @(negedge clock);
      forever begin
         if (rsp_count % 40 == 0) rsp_style = idle_style_type'($urandom_range(0, 2));
         rsp_count++;
         gap = pick_wait(rsp_style);
         if (gap > 0) begin
            rsp_ready <= 1'b0;
            repeat (gap) @(negedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!rsp_valid);
         @(negedge clock);
      end
   end

   // one process per edge both records accepted requests and checks responses,
   // so the order of the two never depends on the scheduler
   always @(posedge clock) begin : answer_check
      answer_type want;
      if (!reset) begin
         if (req_valid && req_ready) begin
            want = table_answer(req_operation, req_address, req_kind);
            if (req_typed) want = req_typed_answer;
            pending_answers.push_back(want);
         end
         if (rsp_valid && rsp_ready) begin
            if (pending_answers.size() == 0) begin
               $display("%0t: response with no request waiting (hit %0b full %0b)",
                        $realtime, rsp_hit, rsp_full_res);
               mismatch_count++;
            end else begin
               want = pending_answers.pop_front();
               if (rsp_hit !== want.hit) begin
                  $display("%0t: hit expected %0b actual %0b", $realtime, want.hit, rsp_hit);
                  mismatch_count++;
               end
               if (rsp_full_res !== want.full) begin
                  $display("%0t: full_res expected %0b actual %0b",
                           $realtime, want.full, rsp_full_res);
                  mismatch_count++;
               end
            end
         end
      end
   end

   // hard stop, well beyond the slowest legal run
   initial begin
      #3_000_000;
      $display("%0t: timeout with %0d responses outstanding", $realtime,
               pending_answers.size());
      $display("Regression FAIL");
      $finish;
   end

   initial begin
      logic [bmt_pkg::OP_BITS-1:0]   op;
      logic [ADDR_BITS-1:0]          addr;
      logic [bmt_pkg::KIND_BITS-1:0] kind;
      int                            set_pct;
      int                            roll;
      int                            drain;

      // every input known from time zero
      reset            = 1'b1;
      req_valid        = 1'b0;
      req_operation    = bmt_pkg::OP_SET;
      req_address      = '0;
      req_kind         = bmt_pkg::KIND_WRITE;
      req_typed        = PREDICT;
      req_typed_answer = '0;
      mismatch_count   = 0;
      req_count        = 0;
      req_style        = IDLE_NONE;
      last_armed       = '0;

      for (int i = 0; i < SLOTS; i++) begin
         shadow_kind[i] = bmt_pkg::KIND_EMPTY;
         shadow_addr[i] = '0;
      end
      shadow_skip_armed = 1'b0;
      shadow_skip_addr  = '0;

      // hot addresses: half random, half one bit away from the first
      for (int i = 0; i < HOT_COUNT / 2; i++) hot_addr[i] = ADDR_BITS'($urandom());
      for (int i = HOT_COUNT / 2; i < HOT_COUNT; i++)
         hot_addr[i] = hot_addr[0] ^ (ADDR_BITS'(1) << $urandom_range(0, ADDR_BITS - 1));

      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // fill every slot once so no stored address is left unwritten,
      // then one more set must report full
      for (int i = 0; i < SLOTS; i++) begin
         if (i == 0) addr = ADDR_MIN;
         else if (i == SLOTS - 1) addr = ADDR_MAX;
         else addr = ADDR_BITS'($urandom());
         send_request(bmt_pkg::OP_SET, addr,
                      (i % 2) ? bmt_pkg::KIND_FETCH : bmt_pkg::KIND_WRITE, TYPED, '0);
      end
      send_request(bmt_pkg::OP_SET, ADDR_BITS'($urandom()), bmt_pkg::KIND_WRITE, TYPED,
                   answer_type'(2'b01));
      send_request(bmt_pkg::OP_CHECK, ADDR_MAX, bmt_pkg::KIND_FETCH, TYPED,
                   answer_type'(2'b10));
      send_request(bmt_pkg::OP_CLEAR, ADDR_MIN, bmt_pkg::KIND_WRITE, TYPED, '0);

      // directed table
      foreach (directed_rows[i])
         send_request(directed_rows[i].op, directed_rows[i].addr, directed_rows[i].kind,
                      directed_rows[i].typed, {directed_rows[i].hit, directed_rows[i].full});

      // random phases; the share of sets swings so the table runs both
      // nearly empty and full
      for (int phase = 0; phase < 14; phase++) begin
         set_pct = $urandom_range(15, 50);
         for (int n = 0; n < 100; n++) begin
            roll = $urandom_range(0, 99);
            addr = pick_address();
            kind = pick_kind();
            if (roll < set_pct) begin
               op = bmt_pkg::OP_SET;
            end else if (roll < set_pct + 8) begin
               op = bmt_pkg::OP_REMOVE;
            end else if (roll < set_pct + 9) begin
               op = bmt_pkg::OP_CLEAR;
            end else if (roll < set_pct + 16) begin
               op = bmt_pkg::OP_ARM;
               last_armed = addr;
            end else if (roll < set_pct + 18) begin
               op = bmt_pkg::OP_BITS'($urandom_range(OP_RSVD_LO, OP_RSVD_HI));
            end else begin
               op = bmt_pkg::OP_CHECK;
               // aim some checks at the armed skip address
               if ($urandom_range(0, 3) == 0) addr = last_armed;
            end
            send_request(op, addr, kind, PREDICT, '0);
         end
      end

      @(negedge clock);
      req_valid <= 1'b0;

      // wait for every outstanding response, bounded
      drain = 0;
      while (pending_answers.size() > 0 && drain < 2000) begin
         @(posedge clock);
         drain++;
      end
      if (pending_answers.size() > 0) begin
         $display("%0t: %0d responses never arrived", $realtime, pending_answers.size());
         mismatch_count += pending_answers.size();
      end

      // keep running after the drain to catch stray responses
      repeat (16) @(posedge clock);

      if (mismatch_count == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule

`default_nettype wire
